// ----- hdl/sha256_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 stream hasher.
// Depends on nothing; imported by sha256_buf_mem, sha256_round and sha256_stream_hasher.
package sha256_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int LEN_POS     = 56;
    localparam int DIGEST_WORDS = 8;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // compression counter: fetch at 0..15, shift at 1..64, round at 2..65, fold at 66
    localparam int CNT_W      = 7;
    localparam int SHIFT_LAST = ROUNDS;
    localparam int ROUND_LAST = ROUNDS + 1;
    localparam int FOLD_CNT   = ROUNDS + 2;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } hash_state_t;

    typedef struct packed {
        logic start;
        logic restart;
    } rnd_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rnd_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ----- hdl/sha256_if.sv -----
// Valid/ready channels of the SHA-256 stream hasher: message bytes in, digest words out.
// Standalone; no package needed.
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source(output valid, data_byte, byte_present, message_end, input ready);
    modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source(output valid, digest_word, word_number, final_word, input ready);
    modport sink(input valid, digest_word, word_number, final_word, output ready);
endinterface

// ----- hdl/sha256_buf_mem.sv -----
// Block buffer: 16 x 32-bit synchronous RAM, byte-lane write enables, registered read.
// Lane 3 holds the first byte of a word (big-endian). Uses sha256_pkg.
module sha256_buf_mem
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  be,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] mem [BLOCK_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (be[b])
                begin
                    mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/sha256_round.sv -----
// Compression engine: fetches the block from the buffer RAM, runs the schedule window
// and 64 rounds one per cycle, then folds into the chaining words. Uses sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rnd_ctl_t    ctl,
    output rnd_stat_t   stat,
    output logic [3:0]  rd_addr,
    input  logic [31:0] rd_data,
    input  logic [2:0]  sel,
    output logic [31:0] sel_word
);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [31:0]      chain_reg [DIGEST_WORDS];
    logic [31:0]      v_reg [DIGEST_WORDS];
    logic [31:0]      w_reg [BLOCK_WORDS];

    logic             shift_en;
    logic             round_en;
    logic             fold_en;
    logic [5:0]       t_idx;
    logic [31:0]      w_new;
    logic [31:0]      t1;
    logic [31:0]      t2;

    always_comb
    begin
        shift_en = busy_reg && (cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_W'(SHIFT_LAST));
        round_en = busy_reg && (cnt_reg >= CNT_W'(2)) && (cnt_reg <= CNT_W'(ROUND_LAST));
        fold_en  = busy_reg && (cnt_reg == CNT_W'(FOLD_CNT));
        t_idx    = 6'(cnt_reg - CNT_W'(2));
        rd_addr  = cnt_reg[3:0];
        // first sixteen words come straight from the buffer, the rest from the window
        if (cnt_reg <= CNT_W'(BLOCK_WORDS))
            w_new = rd_data;
        else
            w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];
        t1 = v_reg[7] + bsig1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
           + ROUND_K[t_idx] + w_reg[15];
        t2 = bsig0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
        stat.busy = busy_reg;
        stat.done = fold_en;
        sel_word  = chain_reg[sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !fold_en;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= INIT_H[i];
        end
        else if (ctl.restart)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= INIT_H[i];
        end
        else if (fold_en)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= chain_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                v_reg[i] <= chain_reg[i];
        end
        else if (round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (shift_en)
        begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++)
                w_reg[j] <= w_reg[j+1];
            w_reg[BLOCK_WORDS-1] <= w_new;
        end
    end

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher: one accepted byte per cycle into the block RAM while idle; each
// full block then stalls the input (16-word fetch overlapped with 64 rounds, then fold).
// Message end: padding up to word 15, compression of one or two blocks, then 8 beats.
// No bytes are accepted while the single round unit of sha256_round compresses a block.
// Reset: chaining words to the initial hash, fill and bit count to zero; RAM uncleared.
// Uses sha256_pkg, sha256_if, sha256_buf_mem, sha256_round.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha256_in_if.sink    msg,
    sha256_out_if.source digest
);

    hash_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [3:0]  pad_word_reg, pad_word_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        mark_en_reg, mark_en_next;
    logic        len_en_reg, len_en_next;
    logic        in_pad_reg, in_pad_next;
    logic        end_pend_reg, end_pend_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    rnd_ctl_t    rnd_ctl;
    rnd_stat_t   rnd_stat;
    logic        mem_we;
    logic [3:0]  mem_be;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_rdata;
    logic [31:0] chain_word;
    logic [5:0]  byte_pos;
    logic [7:0]  pad_byte;

    sha256_buf_mem u_buf (
        .clk   (clk),
        .we    (mem_we),
        .be    (mem_be),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sha256_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rnd_ctl),
        .stat     (rnd_stat),
        .rd_addr  (mem_raddr),
        .rd_data  (mem_rdata),
        .sel      (out_idx_reg),
        .sel_word (chain_word)
    );

    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_word;
    assign digest.word_number = out_idx_reg;
    assign digest.final_word  = (out_idx_reg == 3'(DIGEST_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            pad_word_reg  <= '0;
            pad_pos_reg   <= '0;
            mark_en_reg   <= 1'b0;
            len_en_reg    <= 1'b0;
            in_pad_reg    <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_count_reg <= bit_count_next;
            pad_word_reg  <= pad_word_next;
            pad_pos_reg   <= pad_pos_next;
            mark_en_reg   <= mark_en_next;
            len_en_reg    <= len_en_next;
            in_pad_reg    <= in_pad_next;
            end_pend_reg  <= end_pend_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_count_next = bit_count_reg;
        pad_word_next  = pad_word_reg;
        pad_pos_next   = pad_pos_reg;
        mark_en_next   = mark_en_reg;
        len_en_next    = len_en_reg;
        in_pad_next    = in_pad_reg;
        end_pend_next  = end_pend_reg;
        out_idx_next   = out_idx_reg;
        rnd_ctl        = '0;
        mem_we         = 1'b0;
        mem_be         = '0;
        mem_waddr      = fill_reg[5:2];
        mem_wdata      = {4{msg.data_byte}};
        byte_pos       = '0;
        pad_byte       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.byte_present)
                    begin
                        mem_we         = 1'b1;
                        mem_be         = 4'b1000 >> fill_reg[1:0];
                        fill_next      = fill_reg + 6'd1;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (msg.byte_present && (fill_reg == 6'(BLOCK_WORDS * 4 - 1)))
                    begin
                        // block full: compress first, pad afterwards if the message ends
                        rnd_ctl.start = 1'b1;
                        end_pend_next = msg.message_end;
                        state_next    = ST_COMP;
                    end
                    else if (msg.message_end)
                    begin
                        pad_pos_next  = fill_next;
                        pad_word_next = fill_next[5:2];
                        mark_en_next  = 1'b1;
                        len_en_next   = (fill_next < 6'(LEN_POS));
                        in_pad_next   = 1'b1;
                        state_next    = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = pad_word_reg;
                for (int b = 0; b < 4; b++)
                begin
                    byte_pos = {pad_word_reg, 2'(b)};
                    if (mark_en_reg && (byte_pos == pad_pos_reg))
                        pad_byte = PAD_MARK;
                    else if (len_en_reg && (byte_pos >= 6'(LEN_POS)))
                        pad_byte = bit_count_reg[8 * (7 - byte_pos[2:0]) +: 8];
                    else
                        pad_byte = '0;
                    // keep message bytes below the pad start
                    mem_be[3-b]             = (byte_pos >= pad_pos_reg);
                    mem_wdata[8*(3-b) +: 8] = pad_byte;
                end
                if (pad_word_reg == 4'(BLOCK_WORDS - 1))
                begin
                    rnd_ctl.start = 1'b1;
                    state_next    = ST_COMP;
                end
                else
                begin
                    pad_word_next = pad_word_reg + 4'd1;
                end
            end

            ST_COMP:
            begin
                if (rnd_stat.done)
                begin
                    priority if (in_pad_reg && len_en_reg)
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                    else if (in_pad_reg)
                    begin
                        // extra block: zeros then the length
                        pad_pos_next  = '0;
                        pad_word_next = '0;
                        mark_en_next  = 1'b0;
                        len_en_next   = 1'b1;
                        state_next    = ST_PAD;
                    end
                    else if (end_pend_reg)
                    begin
                        pad_pos_next  = fill_reg;
                        pad_word_next = fill_reg[5:2];
                        mark_en_next  = 1'b1;
                        len_en_next   = (fill_reg < 6'(LEN_POS));
                        in_pad_next   = 1'b1;
                        end_pend_next = 1'b0;
                        state_next    = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_OUT:
            begin
                if (digest.ready)
                begin
                    if (out_idx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        rnd_ctl.restart = 1'b1;
                        fill_next       = '0;
                        bit_count_next  = '0;
                        in_pad_next     = 1'b0;
                        len_en_next     = 1'b0;
                        mark_en_next    = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> !rnd_stat.busy)
        else $error("digest beat while compression is running");

    a_pad_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> !rnd_stat.busy)
        else $error("buffer padded while the round unit reads it");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_ctl.start |-> !rnd_stat.busy)
        else $error("compression started while busy");

    a_restart_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.final_word)
        |=> (state_reg == ST_IDLE && fill_reg == '0 && bit_count_reg == '0))
        else $error("hasher not re-initialized after the last digest beat");
`endif

endmodule
